[sv/assert_macros.svh]
// Assertion shorthands, all clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/wsm_pkg.sv]
package wsm_pkg;

  localparam int DEPTH  = 64;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int WT_W   = 16;
  localparam int MAXW_W = 20;
  localparam int TOT_W  = 21;
  localparam int DROP_W = 7;

  localparam logic [MAXW_W-1:0] MAXW_RESET = MAXW_W'(1024);

  typedef struct packed {
    logic [WT_W-1:0]  sample_weight;
    logic [VAL_W-1:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic [VAL_W-1:0]  median_value;
    logic [DROP_W-1:0] dropped_count;
    logic              capacity_evicted;
  } out_beat_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'b01,
    ALU_SUB = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [TOT_W-1:0] x;
    logic [TOT_W-1:0] y;
    logic [VAL_W-1:0] ca;
    logic [VAL_W-1:0] cb;
  } alu_req_t;

  typedef struct packed {
    logic [TOT_W-1:0] res;
    logic             ge;   // x >= y on subtract
    logic             le;   // ca <= cb
    logic             lt;   // ca < cb
  } alu_rsp_t;

  typedef struct packed {
    logic              we_val;
    logic              we_wt;
    logic [SLOT_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_value;
    logic [WT_W-1:0]   wr_weight;
    logic [SLOT_W-1:0] rd_addr;
  } store_req_t;

  // Circular slot arithmetic: base is a live slot, off is at most DEPTH.
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

[sv/wsm_store.sv]
module wsm_store (
  input  logic                      clk,
  input  wsm_pkg::store_req_t       req,
  output logic [wsm_pkg::VAL_W-1:0] rd_value,
  output logic [wsm_pkg::WT_W-1:0]  rd_weight
);
  import wsm_pkg::*;

  logic [VAL_W-1:0] val_mem [DEPTH];
  logic [WT_W-1:0]  wt_mem  [DEPTH];
  logic [VAL_W-1:0] rd_value_r;
  logic [WT_W-1:0]  rd_weight_r;

  always_ff @(posedge clk) begin
    if (req.we_val) begin
      val_mem[req.wr_addr] <= req.wr_value;
    end
    if (req.we_wt) begin
      wt_mem[req.wr_addr] <= req.wr_weight;
    end
    rd_value_r  <= val_mem[req.rd_addr];
    rd_weight_r <= wt_mem[req.rd_addr];
  end

  assign rd_value  = rd_value_r;
  assign rd_weight = rd_weight_r;

endmodule

[sv/wsm_cmpacc.sv]
module wsm_cmpacc (
  input  wsm_pkg::alu_req_t req,
  output wsm_pkg::alu_rsp_t rsp
);
  import wsm_pkg::*;

  logic [TOT_W:0] sum;
  logic [VAL_W:0] diff;

  always_comb begin
    unique case (req.op)
      ALU_ADD: sum = {1'b0, req.x} + {1'b0, req.y};
      ALU_SUB: sum = {1'b0, req.x} - {1'b0, req.y};
      default: sum = '0;
    endcase
  end

  assign diff    = {1'b0, req.ca} - {1'b0, req.cb};
  assign rsp.res = sum[TOT_W-1:0];
  assign rsp.ge  = ~sum[TOT_W];
  assign rsp.lt  = diff[VAL_W];
  assign rsp.le  = diff[VAL_W] | (diff[VAL_W-1:0] == '0);

endmodule

[sv/weighted_sliding_median.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_data   (sample_weight, sample_value)
// out      output     out_valid/out_stall  out_data  (median, dropped, evicted)
// cfg      input      cfg_we               cfg_wdata (weight limit)
//
// The median pass dominates the work on each sample, with one store read per
// pair of candidate and live entry.
// Synchronous active-low reset empties the window and sets the weight limit to 1024.
// in_stall is high from acceptance until the result is loaded; out_stall only
// holds the last step until the output register frees up.
`include "assert_macros.svh"

module weighted_sliding_median (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wsm_pkg::in_beat_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wsm_pkg::out_beat_t         out_data,
  input  logic                       cfg_we,
  input  logic [wsm_pkg::MAXW_W-1:0] cfg_wdata
);
  import wsm_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_EVICT     = 12'b0000_0000_0010,
    S_INSERT    = 12'b0000_0000_0100,
    S_TR_CHK    = 12'b0000_0000_1000,
    S_TR_CMP    = 12'b0000_0001_0000,
    S_TR_POP    = 12'b0000_0010_0000,
    S_TR_CUT    = 12'b0000_0100_0000,
    S_MED_START = 12'b0000_1000_0000,
    S_MED_V     = 12'b0001_0000_0000,
    S_MED_IN    = 12'b0010_0000_0000,
    S_MED_EVAL  = 12'b0100_0000_0000,
    S_OUT       = 12'b1000_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MAXW_W-1:0] wt_limit_r;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  in_beat_t          beat_r, beat_nxt;
  logic [DROP_W-1:0] dropped_r, dropped_nxt;
  logic              evicted_r, evicted_nxt;
  logic [TOT_W-1:0]  excess_r, excess_nxt;
  logic [WT_W-1:0]   ow_r, ow_nxt;
  logic [TOT_W-1:0]  want_r, want_nxt;
  logic [TOT_W-1:0]  cum_r, cum_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  j_r, j_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic [VAL_W-1:0]  best_r, best_nxt;
  logic              found_r, found_nxt;
  out_beat_t         out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  store_req_t        st_req;
  logic [VAL_W-1:0]  rd_value;
  logic [WT_W-1:0]   rd_weight;

  wsm_store u_store (
    .clk      (clk),
    .req      (st_req),
    .rd_value (rd_value),
    .rd_weight(rd_weight)
  );

  wsm_cmpacc u_cmpacc (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    beat_nxt      = beat_r;
    dropped_nxt   = dropped_r;
    evicted_nxt   = evicted_r;
    excess_nxt    = excess_r;
    ow_nxt        = ow_r;
    want_nxt      = want_r;
    cum_nxt       = cum_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    v_nxt         = v_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;

    alu_req.op = ALU_SUB;
    alu_req.x  = total_r;
    alu_req.y  = '0;
    alu_req.ca = v_r;
    alu_req.cb = best_r;

    st_req.we_val    = 1'b0;
    st_req.we_wt     = 1'b0;
    st_req.wr_addr   = oldest_r;
    st_req.wr_value  = beat_r.sample_value;
    st_req.wr_weight = beat_r.sample_weight;
    st_req.rd_addr   = oldest_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          beat_nxt    = in_data;
          dropped_nxt = '0;
          evicted_nxt = 1'b0;
          // oldest weight is read now in case the store is full
          state_nxt   = (count_r == CNT_W'(DEPTH)) ? S_EVICT : S_INSERT;
        end
      end
      S_EVICT: begin
        alu_req.x   = total_r;
        alu_req.y   = TOT_W'(rd_weight);
        total_nxt   = alu_rsp.res;
        oldest_nxt  = slot_add(oldest_r, CNT_W'(1));
        count_nxt   = count_r - CNT_W'(1);
        evicted_nxt = 1'b1;
        state_nxt   = S_INSERT;
      end
      S_INSERT: begin
        st_req.we_val  = 1'b1;
        st_req.we_wt   = 1'b1;
        st_req.wr_addr = slot_add(oldest_r, count_r);
        alu_req.op     = ALU_ADD;
        alu_req.x      = total_r;
        alu_req.y      = TOT_W'(beat_r.sample_weight);
        total_nxt      = alu_rsp.res;
        count_nxt      = count_r + CNT_W'(1);
        state_nxt      = S_TR_CHK;
      end
      S_TR_CHK: begin
        alu_req.x  = total_r;
        alu_req.y  = TOT_W'(wt_limit_r);
        excess_nxt = alu_rsp.res;
        if (alu_rsp.ge && (alu_rsp.res != '0) && (count_r != '0)) begin
          state_nxt = S_TR_CMP;
        end else begin
          state_nxt = S_MED_START;
        end
      end
      S_TR_CMP: begin
        alu_req.x = excess_r;
        alu_req.y = TOT_W'(rd_weight);
        ow_nxt    = rd_weight;
        state_nxt = alu_rsp.ge ? S_TR_POP : S_TR_CUT;
      end
      S_TR_POP: begin
        alu_req.x   = total_r;
        alu_req.y   = TOT_W'(ow_r);
        total_nxt   = alu_rsp.res;
        oldest_nxt  = slot_add(oldest_r, CNT_W'(1));
        count_nxt   = count_r - CNT_W'(1);
        dropped_nxt = dropped_r + DROP_W'(1);
        state_nxt   = S_TR_CHK;
      end
      S_TR_CUT: begin
        // trim the oldest by the excess; the total lands exactly on the limit
        alu_req.x        = TOT_W'(ow_r);
        alu_req.y        = excess_r;
        st_req.we_wt     = 1'b1;
        st_req.wr_addr   = oldest_r;
        st_req.wr_weight = alu_rsp.res[WT_W-1:0];
        total_nxt        = TOT_W'(wt_limit_r);
        state_nxt        = S_MED_START;
      end
      S_MED_START: begin
        alu_req.op = ALU_ADD;
        alu_req.x  = {1'b0, total_r[TOT_W-1:1]};
        alu_req.y  = TOT_W'(total_r[0]);
        want_nxt   = alu_rsp.res;
        i_nxt      = '0;
        found_nxt  = 1'b0;
        best_nxt   = '0;
        state_nxt  = (count_r == '0) ? S_OUT : S_MED_V;
      end
      S_MED_V: begin
        v_nxt     = rd_value;
        j_nxt     = '0;
        cum_nxt   = '0;
        state_nxt = S_MED_IN;
      end
      S_MED_IN: begin
        alu_req.op     = ALU_ADD;
        alu_req.ca     = rd_value;
        alu_req.cb     = v_r;
        alu_req.x      = cum_r;
        alu_req.y      = TOT_W'(rd_weight);
        // keep the sum only for entries at or below the candidate
        if (alu_rsp.le) begin
          cum_nxt = alu_rsp.res;
        end
        st_req.rd_addr = slot_add(oldest_r, j_r + CNT_W'(1));
        j_nxt          = j_r + CNT_W'(1);
        if (j_r == count_r - CNT_W'(1)) begin
          state_nxt = S_MED_EVAL;
        end
      end
      S_MED_EVAL: begin
        alu_req.x      = cum_r;
        alu_req.y      = want_r;
        alu_req.ca     = v_r;
        alu_req.cb     = best_r;
        st_req.rd_addr = slot_add(oldest_r, i_r + CNT_W'(1));
        if (alu_rsp.ge && (!found_r || alu_rsp.lt)) begin
          best_nxt  = v_r;
          found_nxt = 1'b1;
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = (i_r + CNT_W'(1) == count_r) ? S_OUT : S_MED_V;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.median_value     = best_r;
          out_data_nxt.dropped_count    = dropped_r;
          out_data_nxt.capacity_evicted = evicted_r;
          out_valid_nxt                 = 1'b1;
          state_nxt                     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wt_limit_r  <= MAXW_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        wt_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    beat_r     <= beat_nxt;
    dropped_r  <= dropped_nxt;
    evicted_r  <= evicted_nxt;
    excess_r   <= excess_nxt;
    ow_r       <= ow_nxt;
    want_r     <= want_nxt;
    cum_r      <= cum_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    v_r        <= v_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_NEVER(a_count_range, count_r > CNT_W'(DEPTH), "entry count beyond store depth")
  `ASSERT_NEVER(a_oldest_range, CNT_W'(oldest_r) >= CNT_W'(DEPTH), "oldest slot out of range")
  `ASSERT_NEVER(a_empty_total, state_r == S_IDLE && count_r == '0 && total_r != '0, "stray weight")
  `ASSERT_CLK(a_beat_starts, (in_valid && !in_stall) |=> state_r != S_IDLE, "beat not started")
  `ASSERT_CLK(a_result_src, $rose(out_valid_r) |-> $past(state_r == S_OUT), "stray result")

endmodule
